// ----- rtl/core/cc20_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and round functions of the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int WORD_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int NUM_WORDS = 16;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = 3;
	localparam int POS_W     = 7;

	typedef logic [WORD_W-1:0]                 word_t;
	typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  block_t;
	typedef logic [BYTE_W-1:0]                 byte_t;
	typedef logic [CFG_W-1:0]                  cfg_word_t;
	typedef logic [IDX_W-1:0]                  cfg_index_t;

	localparam word_t [3:0] SIGMA = {
		32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
	};

	localparam int ROT_A = 16;
	localparam int ROT_B = 12;
	localparam int ROT_C = 8;
	localparam int ROT_D = 7;

	typedef enum logic [IDX_W-1:0] {
		CFG_KEY_0     = 3'd0,
		CFG_KEY_1     = 3'd1,
		CFG_KEY_2     = 3'd2,
		CFG_KEY_3     = 3'd3,
		CFG_NONCE_LO  = 3'd4,
		CFG_NONCE_HI  = 3'd5,
		CFG_INIT_CTR  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		cfg_word_t key_0;
		cfg_word_t key_1;
		cfg_word_t key_2;
		cfg_word_t key_3;
		cfg_word_t nonce_lo;
		word_t     nonce_hi;
		word_t     init_ctr;
	} cfg_regs_t;

	typedef struct packed {
		logic start;
		logic abort;
	} gen_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gen_stat_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// One half of a quarter round: the first half rotates by 16 and 12,
	// the second half by 8 and 7.
	function automatic quad_t qr_half(input quad_t q, input logic second);
		quad_t r;
		word_t t;
		r   = q;
		r.a = q.a + q.b;
		t   = q.d ^ r.a;
		r.d = second ? rotl(t, ROT_C) : rotl(t, ROT_A);
		r.c = q.c + r.d;
		t   = q.b ^ r.c;
		r.b = second ? rotl(t, ROT_D) : rotl(t, ROT_B);
		return r;
	endfunction

endpackage

// ----- rtl/core/cc20_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_ifs
// Request channels of the stream cipher: input bytes, result bytes and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface cc20_in_if import cc20_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface cc20_out_if import cc20_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink   (input valid, input result_byte, output ready);
endinterface

interface cc20_cfg_if import cc20_pkg::*; ();
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_word_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/cc20_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_front
// Two-entry request queue that takes input bytes with their restart flag and
// hands them to the keystream side.
// ----------------------------------------------------------------------------
module cc20_front import cc20_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	cc20_in_if.sink      item,
	cc20_in_if.source    head
);

	byte_t      data_q [2];
	logic [1:0] restart_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign item.ready     = (count_q != 2'd2);
	assign push           = item.valid && item.ready;
	assign pop            = head.valid && head.ready;
	assign head.valid     = (count_q != 2'd0);
	assign head.data_byte = data_q[rd_ptr_q];
	assign head.restart   = restart_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= '0;
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			count_q   <= '0;
		end else begin
			if (push) begin
				restart_q[wr_ptr_q] <= item.restart;
				wr_ptr_q            <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= 2'(count_q + 2'd1);
				2'b01:   count_q <= 2'(count_q - 2'd1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/cc20_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_core
// Iterative ChaCha20 block function: each step runs half of all four column
// or diagonal quarter rounds, then the input state is added (feed-forward).
// ----------------------------------------------------------------------------
module cc20_core import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  gen_ctrl_t ctrl,
	input  block_t    init,
	output gen_stat_t stat,
	output block_t    block
);

	localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

	typedef enum logic [2:0] {
		G_IDLE = 3'b001,
		G_RUN  = 3'b010,
		G_FIN  = 3'b100
	} gen_state_t;

	gen_state_t       state_q;
	logic [1:0]       phase_q;
	logic [RND_W-1:0] round_q;
	block_t           w_q;
	block_t           w_next;
	block_t           res_q;
	logic             last_round;

	assign last_round = (round_q == RND_W'(DOUBLE_ROUNDS - 1));
	assign stat.busy  = (state_q != G_IDLE);
	assign stat.done  = (state_q == G_FIN) && !ctrl.abort;
	assign block      = res_q;

	always_comb begin
		quad_t q_in;
		quad_t q_out;
		w_next = w_q;
		for (int i = 0; i < 4; i++) begin
			if (!phase_q[1]) begin
				q_in.a = w_q[i];
				q_in.b = w_q[4 + i];
				q_in.c = w_q[8 + i];
				q_in.d = w_q[12 + i];
				q_out  = qr_half(q_in, phase_q[0]);
				w_next[i]      = q_out.a;
				w_next[4 + i]  = q_out.b;
				w_next[8 + i]  = q_out.c;
				w_next[12 + i] = q_out.d;
			end else begin
				q_in.a = w_q[i];
				q_in.b = w_q[4 + ((i + 1) & 3)];
				q_in.c = w_q[8 + ((i + 2) & 3)];
				q_in.d = w_q[12 + ((i + 3) & 3)];
				q_out  = qr_half(q_in, phase_q[0]);
				w_next[i]                  = q_out.a;
				w_next[4 + ((i + 1) & 3)]  = q_out.b;
				w_next[8 + ((i + 2) & 3)]  = q_out.c;
				w_next[12 + ((i + 3) & 3)] = q_out.d;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			G_IDLE: begin
				w_q <= init;
			end
			G_RUN: begin
				w_q <= w_next;
			end
			G_FIN: begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					res_q[i] <= w_q[i] + init[i];
				end
			end
			default: begin
				w_q <= w_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			phase_q <= '0;
			round_q <= '0;
		end else if (ctrl.abort) begin
			state_q <= G_IDLE;
		end else begin
			unique case (state_q)
				G_IDLE: begin
					phase_q <= '0;
					round_q <= '0;
					if (ctrl.start) begin
						state_q <= G_RUN;
					end
				end
				G_RUN: begin
					phase_q <= 2'(phase_q + 2'd1);
					if (phase_q == 2'd3) begin
						if (last_round) begin
							state_q <= G_FIN;
						end else begin
							round_q <= RND_W'(round_q + 1'b1);
						end
					end
				end
				G_FIN: begin
					state_q <= G_IDLE;
				end
				default: begin
					state_q <= G_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/cc20_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_back
// Keystream side: block counter and live nonce word, current and prefetched
// keystream blocks, byte position, restart handling and the result register.
// ----------------------------------------------------------------------------
module cc20_back import cc20_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cc20_in_if.sink     head,
	cc20_out_if.source  result,
	input  cfg_regs_t   regs,
	input  logic        cfg_wr,
	input  gen_stat_t   gen_stat,
	input  block_t      gen_block,
	output gen_ctrl_t   gen_ctrl,
	output block_t      init
);

	word_t            blk_ctr_q;
	word_t            nonce0_q;
	logic [POS_W-1:0] pos_q;
	logic             pf_valid_q;
	logic             reloaded_q;
	block_t           cur_q;
	logic             out_valid_q;
	byte_t            out_byte_q;

	logic             out_free;
	logic             reload;
	logic             have_ks;
	logic             take;
	logic             swap;
	word_t            ks_word;
	logic [1:0]       ks_sel;
	byte_t            ks_byte;

	assign out_free = !out_valid_q || result.ready;
	assign reload   = head.valid && head.restart && !reloaded_q;
	assign have_ks  = !pos_q[POS_W-1] || pf_valid_q;
	assign take     = head.valid && !reload && have_ks && out_free;
	assign swap     = take && pos_q[POS_W-1];

	assign head.ready         = take;
	assign result.valid       = out_valid_q;
	assign result.result_byte = out_byte_q;

	assign gen_ctrl.abort = reload || cfg_wr;
	assign gen_ctrl.start = !pf_valid_q && !gen_stat.busy && !gen_ctrl.abort;

	always_comb begin
		init[0]  = SIGMA[0];
		init[1]  = SIGMA[1];
		init[2]  = SIGMA[2];
		init[3]  = SIGMA[3];
		init[4]  = regs.key_0[31:0];
		init[5]  = regs.key_0[63:32];
		init[6]  = regs.key_1[31:0];
		init[7]  = regs.key_1[63:32];
		init[8]  = regs.key_2[31:0];
		init[9]  = regs.key_2[63:32];
		init[10] = regs.key_3[31:0];
		init[11] = regs.key_3[63:32];
		init[12] = blk_ctr_q;
		init[13] = nonce0_q;
		init[14] = regs.nonce_lo[63:32];
		init[15] = regs.nonce_hi;
	end

	// When the current block is used up, the first byte comes straight from
	// the prefetched block in the same cycle that it is moved in.
	assign ks_word = pos_q[POS_W-1] ? gen_block[0] : cur_q[pos_q[5:2]];
	assign ks_sel  = pos_q[POS_W-1] ? 2'd0 : pos_q[1:0];
	assign ks_byte = ks_word[{ks_sel, 3'b000} +: BYTE_W];

	always_ff @(posedge clk) begin
		if (swap) begin
			cur_q <= gen_block;
		end
		if (take) begin
			out_byte_q <= head.data_byte ^ ks_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_ctr_q   <= '0;
			nonce0_q    <= '0;
			pos_q       <= POS_W'(64);
			pf_valid_q  <= 1'b0;
			reloaded_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (reload) begin
				blk_ctr_q  <= regs.init_ctr;
				nonce0_q   <= regs.nonce_lo[31:0];
				pos_q      <= POS_W'(64);
				reloaded_q <= 1'b1;
			end else if (take) begin
				reloaded_q <= 1'b0;
				if (swap) begin
					pos_q     <= POS_W'(1);
					blk_ctr_q <= blk_ctr_q + 32'd1;
					if (blk_ctr_q == '1) begin
						nonce0_q <= nonce0_q + 32'd1;
					end
				end else begin
					pos_q <= POS_W'(pos_q + 1'b1);
				end
			end

			if (gen_ctrl.abort || swap) begin
				pf_valid_q <= 1'b0;
			end else if (gen_stat.done) begin
				pf_valid_q <= 1'b1;
			end

			if (take) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/chacha20_stream_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// Byte-wide ChaCha20 encryptor and decryptor with a configuration port.
//
// Each request on the item channel carries one byte and a restart flag; the
// result channel returns that byte XORed with the next keystream byte, in
// order. A restart reloads the block counter and the first nonce word from
// configuration and drops the buffered keystream before the byte is used.
// The cfg channel writes key, nonce and initial counter registers by index
// and is always ready; the user must see that it is written only while no
// request is in flight; the block itself does not enforce this. The next
// keystream block is made in the iterative round unit while the current one
// is consumed, so with the default DOUBLE_ROUNDS one byte per cycle is
// sustained while requests arrive and the receiver is ready. A result is
// valid in the cycle after its request is taken from the head of the
// two-entry input queue. The first byte after reset or after a restart waits
// for a fresh block. Reset clears the configuration registers, the counter
// and nonce word to zero. A stalled receiver holds the result register;
// the queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	cc20_in_if.sink     item,
	cc20_out_if.source  result,
	cc20_cfg_if.sink    cfg
);

	cfg_regs_t regs_q;
	logic      cfg_wr;
	gen_ctrl_t gen_ctrl;
	gen_stat_t gen_stat;
	block_t    gen_block;
	block_t    init;

	cc20_in_if queue_ch ();

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_KEY_0:    regs_q.key_0    <= cfg.data;
				CFG_KEY_1:    regs_q.key_1    <= cfg.data;
				CFG_KEY_2:    regs_q.key_2    <= cfg.data;
				CFG_KEY_3:    regs_q.key_3    <= cfg.data;
				CFG_NONCE_LO: regs_q.nonce_lo <= cfg.data;
				CFG_NONCE_HI: regs_q.nonce_hi <= cfg.data[31:0];
				CFG_INIT_CTR: regs_q.init_ctr <= cfg.data[31:0];
				default:      regs_q          <= regs_q;
			endcase
		end
	end

	cc20_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.head   (queue_ch.source)
	);

	cc20_core #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (gen_ctrl),
		.init   (init),
		.stat   (gen_stat),
		.block  (gen_block)
	);

	cc20_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (queue_ch.sink),
		.result    (result),
		.regs      (regs_q),
		.cfg_wr    (cfg_wr),
		.gen_stat  (gen_stat),
		.gen_block (gen_block),
		.gen_ctrl  (gen_ctrl),
		.init      (init)
	);

endmodule

// ----- sim/chacha20_stream_cipher_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_checker
// Watches the configuration, item and result channels of the stream cipher.
// It keeps its own copy of the registers, block counter, nonce word and
// keystream block, computes the expected result byte of every accepted item
// and compares the results in order. Mismatches, unexpected results and missing results are counted for the top.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_checker import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic end_of_test,
	cc20_in_if   item,
	cc20_out_if  result,
	cc20_cfg_if  cfg,
	output int   errors
);

	localparam int REPORT_LIMIT = 10;

	cfg_regs_t        regs;
	word_t            blk_ctr;
	word_t            nonce_w0;
	block_t           ks;
	logic [POS_W-1:0] pos;
	byte_t            expected_bytes[$];
	logic             leftover_done;

	function automatic word_t rol(input word_t v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	function automatic block_t qround(input block_t s, input int a, input int b,
			input int c, input int d);
		block_t x;
		x = s;
		x[a] = x[a] + x[b];
		x[d] = rol(x[d] ^ x[a], 16);
		x[c] = x[c] + x[d];
		x[b] = rol(x[b] ^ x[c], 12);
		x[a] = x[a] + x[b];
		x[d] = rol(x[d] ^ x[a], 8);
		x[c] = x[c] + x[d];
		x[b] = rol(x[b] ^ x[c], 7);
		return x;
	endfunction

	function automatic block_t make_keystream(input cfg_regs_t r, input word_t ctr,
			input word_t n0);
		block_t init;
		block_t x;
		int i;
		init[0]  = 32'h61707865;
		init[1]  = 32'h3320646e;
		init[2]  = 32'h79622d32;
		init[3]  = 32'h6b206574;
		init[4]  = r.key_0[31:0];
		init[5]  = r.key_0[63:32];
		init[6]  = r.key_1[31:0];
		init[7]  = r.key_1[63:32];
		init[8]  = r.key_2[31:0];
		init[9]  = r.key_2[63:32];
		init[10] = r.key_3[31:0];
		init[11] = r.key_3[63:32];
		init[12] = ctr;
		init[13] = n0;
		init[14] = r.nonce_lo[63:32];
		init[15] = r.nonce_hi;
		x = init;
		for (i = 0; i < DOUBLE_ROUNDS; i++) begin
			x = qround(x, 0, 4, 8, 12);
			x = qround(x, 1, 5, 9, 13);
			x = qround(x, 2, 6, 10, 14);
			x = qround(x, 3, 7, 11, 15);
			x = qround(x, 0, 5, 10, 15);
			x = qround(x, 1, 6, 11, 12);
			x = qround(x, 2, 7, 8, 13);
			x = qround(x, 3, 4, 9, 14);
		end
		for (i = 0; i < NUM_WORDS; i++) begin
			x[i] = x[i] + init[i];
		end
		return x;
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		byte_t ks_byte;
		byte_t want;
		if (!arst_n) begin
			regs          = '0;
			blk_ctr       = '0;
			nonce_w0      = '0;
			ks            = '0;
			pos           = 7'd64;
			errors        = 0;
			leftover_done = 1'b0;
			expected_bytes.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					CFG_KEY_0:    regs.key_0    = cfg.data;
					CFG_KEY_1:    regs.key_1    = cfg.data;
					CFG_KEY_2:    regs.key_2    = cfg.data;
					CFG_KEY_3:    regs.key_3    = cfg.data;
					CFG_NONCE_LO: regs.nonce_lo = cfg.data;
					CFG_NONCE_HI: regs.nonce_hi = cfg.data[WORD_W-1:0];
					CFG_INIT_CTR: regs.init_ctr = cfg.data[WORD_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				if (item.restart) begin
					blk_ctr  = regs.init_ctr;
					nonce_w0 = regs.nonce_lo[WORD_W-1:0];
					pos      = 7'd64;
				end
				if (pos >= 7'd64) begin
					ks      = make_keystream(regs, blk_ctr, nonce_w0);
					blk_ctr = blk_ctr + 32'd1;
					if (blk_ctr == '0)
						nonce_w0 = nonce_w0 + 32'd1;
					pos = '0;
				end
				ks_byte = ks[pos[5:2]][{pos[1:0], 3'b000} +: BYTE_W];
				pos     = pos + 7'd1;
				expected_bytes.push_back(item.data_byte ^ ks_byte);
			end
			if (result.valid && result.ready) begin
				if (expected_bytes.size() == 0) begin
					if (errors < REPORT_LIMIT)
						$display("checker: unexpected result byte %02h", result.result_byte);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (result.result_byte !== want) begin
						if (errors < REPORT_LIMIT)
							$display("checker: result byte expected %02h actual %02h",
								want, result.result_byte);
						errors++;
					end
				end
			end
			if (end_of_test && !leftover_done) begin
				leftover_done = 1'b1;
				if (expected_bytes.size() != 0) begin
					$display("checker: %0d expected result bytes never arrived",
						expected_bytes.size());
					errors += expected_bytes.size();
				end
			end
		end
	end

endmodule

// ----- sim/chacha20_stream_cipher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_tb
// Stimulus and verdict for the stream cipher. After reset the registers are
// programmed and a short directed run covers byte extremes, the stream with
// no restart and back-to-back restarts. Random phases follow under random,
// all-ones, all-zeros and near-wrap settings, with random gaps on both
// channels, phases without gaps and one long receiver hold-off.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_tb;
	import cc20_pkg::*;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 290;
	localparam int MAX_GAP       = 13;
	localparam int HOLD_AT       = 700;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 4 * DOUBLE_ROUNDS + 20;
	localparam int CYCLE_LIMIT   = 400000;

	localparam cfg_index_t CFG_SPARE_IDX = 3'd7;

	typedef enum int {
		KEYS_RANDOM,
		KEYS_ONES,
		KEYS_ZEROS,
		KEYS_NEAR_WRAP
	} key_set_t;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic no_idle     = 1'b0;
	logic end_of_test = 1'b0;
	int   n_sent      = 0;
	int   n_results   = 0;
	int   errors;

	cc20_in_if  item();
	cc20_out_if result();
	cc20_cfg_if cfg();

	chacha20_stream_cipher #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg(cfg)
	);

	chacha20_stream_cipher_checker #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.end_of_test(end_of_test),
		.item(item),
		.result(result),
		.cfg(cfg),
		.errors(errors)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin : receiver
		int gap;
		result.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (n_results == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
			n_results++;
		end
	end

	function automatic cfg_regs_t make_regs(input key_set_t k);
		cfg_regs_t r;
		r = '0;
		case (k)
			KEYS_ONES:  r = '1;
			KEYS_ZEROS: r = '0;
			default: begin
				r.key_0    = {$urandom, $urandom};
				r.key_1    = {$urandom, $urandom};
				r.key_2    = {$urandom, $urandom};
				r.key_3    = {$urandom, $urandom};
				r.nonce_lo = {$urandom, $urandom};
				r.nonce_hi = $urandom;
				r.init_ctr = (k == KEYS_NEAR_WRAP) ? 32'hFFFF_FFFE : $urandom;
			end
		endcase
		return r;
	endfunction

	task automatic send_byte(input byte_t d, input logic rs);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.data_byte <= d;
		item.restart   <= rs;
		item.valid     <= 1'b1;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_word_t v);
		cfg.index <= idx;
		cfg.data  <= v;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic program_regs(input cfg_regs_t r, input logic spare);
		write_reg(CFG_KEY_0, r.key_0);
		write_reg(CFG_KEY_1, r.key_1);
		write_reg(CFG_KEY_2, r.key_2);
		write_reg(CFG_KEY_3, r.key_3);
		write_reg(CFG_NONCE_LO, r.nonce_lo);
		write_reg(CFG_NONCE_HI, {$urandom, r.nonce_hi});
		write_reg(CFG_INIT_CTR, {$urandom, r.init_ctr});
		if (spare)
			write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
		cfg.valid <= 1'b0;
	endtask

	task automatic drain;
		item.valid <= 1'b0;
		while (n_results != n_sent) @(posedge clk);
	endtask

	initial begin : stimulus
		key_set_t plan [NUM_PHASES];
		int p;
		int i;
		plan = '{KEYS_RANDOM, KEYS_ONES, KEYS_NEAR_WRAP, KEYS_ZEROS, KEYS_RANDOM, KEYS_ONES};
		item.valid     <= 1'b0;
		item.data_byte <= '0;
		item.restart   <= 1'b0;
		cfg.valid      <= 1'b0;
		cfg.index      <= CFG_KEY_0;
		cfg.data       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The stream starts from counter zero until the first restart.
		program_regs(make_regs(KEYS_RANDOM), 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		for (i = 0; i < 10; i++)
			send_byte(byte_t'($urandom_range(0, 255)), i == 5);
		drain();

		for (p = 0; p < NUM_PHASES; p++) begin
			no_idle = (p == 2) || (p == 5);
			program_regs(make_regs(plan[p]), p == 3);
			send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
			for (i = 1; i < PHASE_ITEMS; i++)
				send_byte(byte_t'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
